@@ rtl/msp_pkg.sv @@
// Package for the multi-stack shared-pool block: field widths, codes, state type.
// No dependencies; imported by the top level.
package msp_pkg;

    localparam int STACK_IDX_W = 10;
    localparam int VALUE_W     = 32;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

endpackage

@@ rtl/multi_stack_shared_pool.sv @@
// Many LIFO stacks kept as linked lists over one shared node pool.
// Depends on msp_pkg and msp_ram (head memory and node memory).
// A push or an empty pop ends in S_EXEC after the head memory read; a pop reads the node
// memory and ends in S_POP. The input is stalled from accept until the result is written
// to the output register, which an output stall can hold off. Reset: a clearing pass
// empties every stack in the head memory; the input stays stalled until it ends.
module multi_stack_shared_pool #(
    parameter int NUM_STACKS = 1024,
    parameter int POOL_DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  msp_pkg::t_mode                        i_mode,
    input  logic [msp_pkg::STACK_IDX_W-1:0]       i_stack_index,
    input  logic signed [msp_pkg::VALUE_W-1:0]    i_push_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [msp_pkg::VALUE_W-1:0]    o_pop_value,
    output msp_pkg::t_status                      o_status
);

    import msp_pkg::*;

    localparam int HEAD_AW = $clog2(NUM_STACKS);
    localparam int PTR_W   = $clog2(POOL_DEPTH);
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int HEAD_W  = 1 + PTR_W;
    localparam int NODE_W  = VALUE_W + 1 + PTR_W;

    function automatic logic [HEAD_AW-1:0] reduce_index(input logic [STACK_IDX_W-1:0] x);
        logic [31:0] r;
        r = 32'(x);
        for (int j = STACK_IDX_W - 1; j >= 0; j--) begin
            if (r >= (32'(NUM_STACKS) << j)) begin
                r = r - (32'(NUM_STACKS) << j);
            end
        end
        return HEAD_AW'(r);
    endfunction

    t_state                     r_state, n_state;
    logic [HEAD_AW-1:0]         r_clr, n_clr;
    t_mode                      r_mode, n_mode;
    logic [HEAD_AW-1:0]         r_k, n_k;
    logic signed [VALUE_W-1:0]  r_value, n_value;
    logic                       r_free_valid, n_free_valid;
    logic [PTR_W-1:0]           r_free_top, n_free_top;
    logic [CNT_W-1:0]           r_fresh, n_fresh;
    logic                       r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0]  r_pop_value, n_pop_value;
    t_status                    r_status, n_status;

    logic                       head_wr_en, head_rd_en;
    logic [HEAD_AW-1:0]         head_wr_addr, head_rd_addr;
    logic [HEAD_W-1:0]          head_wr_data, head_q;
    logic                       node_wr_en, node_rd_en;
    logic [PTR_W-1:0]           node_wr_addr, node_rd_addr;
    logic [NODE_W-1:0]          node_wr_data, node_q;

    logic                       accept, out_ok;
    logic                       head_ne, link_valid;
    logic [PTR_W-1:0]           head_top, link_idx;
    logic [VALUE_W-1:0]         node_data;

    msp_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_STACKS)) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (head_wr_en),
        .i_wr_addr (head_wr_addr),
        .i_wr_data (head_wr_data),
        .i_rd_en   (head_rd_en),
        .i_rd_addr (head_rd_addr),
        .o_rd_data (head_q)
    );

    msp_ram #(.WIDTH(NODE_W), .DEPTH(POOL_DEPTH)) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (node_wr_en),
        .i_wr_addr (node_wr_addr),
        .i_wr_data (node_wr_data),
        .i_rd_en   (node_rd_en),
        .i_rd_addr (node_rd_addr),
        .o_rd_data (node_q)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_ok     = !r_out_valid || !i_out_stall;

    assign head_ne    = head_q[PTR_W];
    assign head_top   = head_q[PTR_W-1:0];
    assign node_data  = node_q[NODE_W-1 -: VALUE_W];
    assign link_valid = node_q[PTR_W];
    assign link_idx   = node_q[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_free_valid <= 1'b0;
            r_fresh      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_free_valid <= n_free_valid;
            r_fresh      <= n_fresh;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_k         <= n_k;
        r_value     <= n_value;
        r_free_top  <= n_free_top;
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_mode       = r_mode;
        n_k          = r_k;
        n_value      = r_value;
        n_free_valid = r_free_valid;
        n_free_top   = r_free_top;
        n_fresh      = r_fresh;
        n_out_valid  = r_out_valid && i_out_stall;
        n_pop_value  = r_pop_value;
        n_status     = r_status;

        head_wr_en   = 1'b0;
        head_wr_addr = r_k;
        head_wr_data = '0;
        head_rd_en   = 1'b0;
        head_rd_addr = reduce_index(i_stack_index);
        node_wr_en   = 1'b0;
        node_wr_addr = head_top;
        node_wr_data = '0;
        node_rd_en   = 1'b0;
        node_rd_addr = r_free_top;

        unique case (r_state)
            S_CLEAR: begin
                head_wr_en   = 1'b1;
                head_wr_addr = r_clr;
                n_clr        = r_clr + HEAD_AW'(1);
                if (r_clr == HEAD_AW'(NUM_STACKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    head_rd_en = 1'b1;
                    node_rd_en = 1'b1;
                    n_mode     = i_mode;
                    n_k        = reduce_index(i_stack_index);
                    n_value    = i_push_value;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_mode == MODE_PUSH) begin
                    if (out_ok) begin
                        n_out_valid  = 1'b1;
                        n_pop_value  = '0;
                        n_status     = ST_PUSHED;
                        n_state      = S_IDLE;
                        node_wr_data = {r_value, head_ne, head_top};
                        head_wr_addr = r_k;
                        if (r_free_valid) begin
                            node_wr_en   = 1'b1;
                            node_wr_addr = r_free_top;
                            head_wr_en   = 1'b1;
                            head_wr_data = {1'b1, r_free_top};
                            n_free_valid = link_valid;
                            n_free_top   = link_idx;
                        end else if (r_fresh != CNT_W'(POOL_DEPTH)) begin
                            node_wr_en   = 1'b1;
                            node_wr_addr = r_fresh[PTR_W-1:0];
                            head_wr_en   = 1'b1;
                            head_wr_data = {1'b1, r_fresh[PTR_W-1:0]};
                            n_fresh      = r_fresh + CNT_W'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end
                end else if (!head_ne) begin
                    if (out_ok) begin
                        n_out_valid = 1'b1;
                        n_pop_value = '0;
                        n_status    = ST_EMPTY;
                        n_state     = S_IDLE;
                    end
                end else begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = head_top;
                    n_state      = S_POP;
                end
            end
            S_POP: begin
                if (out_ok) begin
                    node_wr_en   = 1'b1;
                    node_wr_addr = head_top;
                    node_wr_data = {node_data, r_free_valid, r_free_top};
                    head_wr_en   = 1'b1;
                    head_wr_addr = r_k;
                    head_wr_data = {link_valid, link_idx};
                    n_free_valid = 1'b1;
                    n_free_top   = head_top;
                    n_out_valid  = 1'b1;
                    n_pop_value  = node_data;
                    n_status     = ST_POPPED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CNT_W'(POOL_DEPTH))
        else $error("fresh count beyond pool depth");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_POP))
        else $error("result raised outside an execute state");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && out_ok) |=> (r_free_valid && r_state == S_IDLE))
        else $error("pop did not return its node to the free list");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr == HEAD_AW'(NUM_STACKS - 1)) |=> r_state == S_IDLE)
        else $error("clearing pass did not end");

    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL)
            |-> (!r_free_valid && r_fresh == CNT_W'(POOL_DEPTH)))
        else $error("push dropped while the pool had room");

endmodule

@@ rtl/msp_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies; used for the head and node memories.
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
